>>> hdl/fmac_pkg.sv
package fmac_pkg;

   localparam int MAX_TAPS = 2048;
   localparam int ADDR_W   = $clog2(MAX_TAPS);
   localparam int TAP_W    = $clog2(MAX_TAPS + 1);

   localparam int INDEX_W  = 11;
   localparam int VALUE_W  = 16;
   localparam int CFG_W    = 12;
   localparam int PROD_W   = 32;
   localparam int OUT_W    = 43;

   localparam logic [CFG_W-1:0] TAP_COUNT_RESET = 12'd2048;

   localparam logic CMD_FILTER = 1'b0;
   localparam logic CMD_LOAD   = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic             push;
      logic             load;
      logic             issue;
      logic [TAP_W-1:0] tap;
      logic             take;
   } ctrl_type;

   typedef struct packed {
      logic busy;
   } stat_type;

endpackage

>>> hdl/fmac_datapath.sv
module fmac_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  fmac_pkg::ctrl_type                   ctrl,
   output fmac_pkg::stat_type                   stat,
   input  logic        [fmac_pkg::INDEX_W-1:0]  req_coef_index,
   input  logic signed [fmac_pkg::VALUE_W-1:0]  req_value,
   output logic signed [fmac_pkg::OUT_W-1:0]    rsp_filter_out
);

   logic signed [fmac_pkg::VALUE_W-1:0] hist_mem [fmac_pkg::MAX_TAPS];
   logic signed [fmac_pkg::VALUE_W-1:0] coef_mem [fmac_pkg::MAX_TAPS];

   logic [fmac_pkg::ADDR_W-1:0] wr_pos_ff, wr_pos_in;
   logic [fmac_pkg::ADDR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [fmac_pkg::TAP_W-1:0]  fill_ff, fill_in;
   logic                        s1_valid_ff, s2_valid_ff;
   logic                        s1_live_ff;
   logic signed [fmac_pkg::VALUE_W-1:0] coef_rd_ff, hist_rd_ff;
   logic signed [fmac_pkg::PROD_W-1:0]  prod_ff;
   logic signed [fmac_pkg::OUT_W-1:0]   acc_ff;
   logic signed [fmac_pkg::OUT_W-1:0]   out_ff;
   logic                        coef_we;
   logic [fmac_pkg::ADDR_W-1:0] coef_wr_addr;

   assign wr_pos_in = (wr_pos_ff == fmac_pkg::ADDR_W'(fmac_pkg::MAX_TAPS - 1)) ?
                      '0 : wr_pos_ff + 1'b1;
   assign rd_ptr_in = ctrl.push ? wr_pos_in :
                      (rd_ptr_ff == '0) ? fmac_pkg::ADDR_W'(fmac_pkg::MAX_TAPS - 1) :
                      rd_ptr_ff - 1'b1;
   assign fill_in   = (fill_ff == fmac_pkg::TAP_W'(fmac_pkg::MAX_TAPS)) ?
                      fill_ff : fill_ff + 1'b1;

   assign coef_we      = ctrl.load && (32'(req_coef_index) < fmac_pkg::MAX_TAPS);
   assign coef_wr_addr = fmac_pkg::ADDR_W'(req_coef_index);

   // memories
   always_ff @(posedge clock) begin
      if (ctrl.push) begin
         hist_mem[wr_pos_in] <= req_value;
      end
      if (ctrl.issue) begin
         hist_rd_ff <= hist_mem[rd_ptr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (coef_we) begin
         coef_mem[coef_wr_addr] <= req_value;
      end
      if (ctrl.issue) begin
         coef_rd_ff <= coef_mem[ctrl.tap[fmac_pkg::ADDR_W-1:0]];
      end
   end

   // write pointer, fill count and pipeline valids
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_pos_ff   <= '0;
         fill_ff     <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (ctrl.push) begin
            wr_pos_ff <= wr_pos_in;
            fill_ff   <= fill_in;
         end
         s1_valid_ff <= ctrl.issue;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   // taps beyond the fill count give a zero product
   always_ff @(posedge clock) begin
      if (ctrl.push || ctrl.issue) begin
         rd_ptr_ff <= rd_ptr_in;
      end
      if (ctrl.issue) begin
         s1_live_ff <= ctrl.tap < fill_ff;
      end
      if (s1_valid_ff) begin
         if (s1_live_ff) begin
            prod_ff <= coef_rd_ff * hist_rd_ff;
         end else begin
            prod_ff <= '0;
         end
      end
      if (ctrl.push) begin
         acc_ff <= '0;
      end else if (s2_valid_ff) begin
         acc_ff <= acc_ff + fmac_pkg::OUT_W'(prod_ff);
      end
      if (ctrl.take) begin
         out_ff <= acc_ff;
      end
   end

   assign stat.busy      = s1_valid_ff || s2_valid_ff;
   assign rsp_filter_out = out_ff;

endmodule

>>> hdl/fmac_controller.sv
module fmac_controller (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_command,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [fmac_pkg::CFG_W-1:0]     csr_tap_count,
   output fmac_pkg::ctrl_type             ctrl,
   input  fmac_pkg::stat_type             stat
);

   fmac_pkg::state_type state_ff, state_in;

   logic [fmac_pkg::CFG_W-1:0] tap_count_ff;
   logic [fmac_pkg::TAP_W-1:0] tap_ff, tap_in;
   logic [fmac_pkg::TAP_W-1:0] taps_used;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       req_fire;
   logic                       last_tap;
   logic                       slot_free;

   always_comb begin
      if (tap_count_ff == '0) begin
         taps_used = fmac_pkg::TAP_W'(1);
      end else if (32'(tap_count_ff) > fmac_pkg::MAX_TAPS) begin
         taps_used = fmac_pkg::TAP_W'(fmac_pkg::MAX_TAPS);
      end else begin
         taps_used = fmac_pkg::TAP_W'(tap_count_ff);
      end
   end

   assign req_fire  = req_valid && req_ready;
   assign last_tap  = tap_ff == taps_used - 1'b1;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         fmac_pkg::ST_IDLE: begin
            if (req_valid && req_command == fmac_pkg::CMD_FILTER) begin
               state_in = fmac_pkg::ST_RUN;
            end
         end
         fmac_pkg::ST_RUN: begin
            if (last_tap) begin
               state_in = fmac_pkg::ST_FINISH;
            end
         end
         fmac_pkg::ST_FINISH: begin
            if (!stat.busy && slot_free) begin
               state_in = fmac_pkg::ST_IDLE;
            end
         end
         default: state_in = fmac_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready  = 1'b0;
      ctrl.push  = 1'b0;
      ctrl.load  = 1'b0;
      ctrl.issue = 1'b0;
      ctrl.tap   = tap_ff;
      ctrl.take  = 1'b0;
      case (state_ff)
         fmac_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            ctrl.push = req_fire && req_command == fmac_pkg::CMD_FILTER;
            ctrl.load = req_fire && req_command == fmac_pkg::CMD_LOAD;
         end
         fmac_pkg::ST_RUN: begin
            ctrl.issue = 1'b1;
         end
         fmac_pkg::ST_FINISH: begin
            ctrl.take = !stat.busy && slot_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   assign tap_in       = ctrl.push ? '0 : (ctrl.issue ? tap_ff + 1'b1 : tap_ff);
   assign rsp_valid_in = ctrl.take ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fmac_pkg::ST_IDLE;
         tap_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         tap_count_ff <= fmac_pkg::TAP_COUNT_RESET;
      end else begin
         state_ff     <= state_in;
         tap_ff       <= tap_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            tap_count_ff <= csr_tap_count;
         end
      end
   end

   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;

endmodule

>>> hdl/fir_filter_mac_top.sv
// fir_filter_mac_top: direct-form fir filter on one shared multiply-accumulate
//
// req channel: req_command selects a sample beat (filter) or a coefficient
// load beat; req_coef_index addresses the load, req_value carries the Q1.15
// sample or coefficient. a load does not start a run and gives no result.
// rsp channel: one beat per sample, rsp_filter_out is the exact Q13.30 sum.
// csr channel: csr_tap_count sets the number of taps (0 acts as 1, values
// above 2048 act as 2048); write only while the filter is idle.
// after a sample is accepted, with n being the taps in use, the single
// multiplier walks the coefficient and history memories one tap per cycle
// for n taps, then the product and sum stages drain and the output register
// loads. req_ready returns right when the result is loaded into the output
// register, so a new sample is taken only after the last one is finished.
// if the receiver stalls, the finished result waits in the output register
// while the next sample is taken and computed; that sample's result holds in
// the accumulator until the output register is free.
// reset (synchronous) empties the sample history by clearing its fill count,
// sets tap count to 2048 and drops rsp_valid; coefficients keep no reset.
module fir_filter_mac_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_command,
   input  logic        [fmac_pkg::INDEX_W-1:0] req_coef_index,
   input  logic signed [fmac_pkg::VALUE_W-1:0] req_value,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [fmac_pkg::OUT_W-1:0]   rsp_filter_out,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic        [fmac_pkg::CFG_W-1:0]   csr_tap_count
);

   fmac_pkg::ctrl_type ctrl;
   fmac_pkg::stat_type stat;

   fmac_controller u_controller (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_command   (req_command),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_tap_count (csr_tap_count),
      .ctrl          (ctrl),
      .stat          (stat)
   );

   fmac_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .ctrl           (ctrl),
      .stat           (stat),
      .req_coef_index (req_coef_index),
      .req_value      (req_value),
      .rsp_filter_out (rsp_filter_out)
   );

endmodule

>>> hdl/fmac_checker.sv
module fmac_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic                                req_command,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic signed [fmac_pkg::OUT_W-1:0]   rsp_filter_out
);

   // stalled result beat holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_filter_out))
      else $error("result beat changed while stalled");

   // a load beat never produces a result
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_command == fmac_pkg::CMD_LOAD && !rsp_valid
      |=> !rsp_valid)
      else $error("load beat produced a result");

   // a sample beat keeps the filter busy
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_command == fmac_pkg::CMD_FILTER |=> !req_ready)
      else $error("sample beat did not start a run");

   // a new result appears only as the run ends
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> req_ready)
      else $error("result raised while still running");

   // reset leaves the filter idle with no result
   assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("bad state after reset");

endmodule

bind fir_filter_mac_top fmac_checker u_fmac_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .req_command    (req_command),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_filter_out (rsp_filter_out)
);

>>> sim/tb_fir_filter_mac_top.sv
`timescale 1ns / 1ps

module tb_fir_filter_mac_top;

   localparam int LOADED_TAPS = 40;

   typedef enum logic [1:0] {
      ROW_LOAD,
      ROW_SAMPLE,
      ROW_TAPS
   } row_kind_type;

   typedef struct {
      row_kind_type                        kind;
      logic [fmac_pkg::INDEX_W-1:0]        idx;
      logic signed [fmac_pkg::VALUE_W-1:0] val;
      logic [fmac_pkg::CFG_W-1:0]          taps;
      bit                                  typed;
      logic signed [fmac_pkg::OUT_W-1:0]   known_sum;
   } stim_row_type;

   logic                                clock          = 1'b0;
   logic                                reset          = 1'b1;
   logic                                req_valid      = 1'b0;
   logic                                req_ready;
   logic                                req_command    = fmac_pkg::CMD_FILTER;
   logic [fmac_pkg::INDEX_W-1:0]        req_coef_index = '0;
   logic signed [fmac_pkg::VALUE_W-1:0] req_value      = '0;
   logic                                rsp_valid;
   logic                                rsp_ready      = 1'b0;
   logic signed [fmac_pkg::OUT_W-1:0]   rsp_filter_out;
   logic                                csr_valid      = 1'b0;
   logic                                csr_ready;
   logic [fmac_pkg::CFG_W-1:0]          csr_tap_count  = '0;

   // filter state as the block should hold it
   logic signed [fmac_pkg::VALUE_W-1:0] hist_mem [fmac_pkg::MAX_TAPS];
   logic signed [fmac_pkg::VALUE_W-1:0] coef_mem [fmac_pkg::MAX_TAPS];
   int                                  newest_pos;
   logic [fmac_pkg::CFG_W-1:0]          taps_reg;

   logic signed [fmac_pkg::OUT_W-1:0]   sum_queue [$];
   logic signed [fmac_pkg::OUT_W-1:0]   want_sum;
   stim_row_type                        dir_rows [$];
   int                                  send_idle = 0;
   int                                  recv_idle = 0;
   int                                  fail_count = 0;
   int plan_taps [8]  = '{16, 1, 37, LOADED_TAPS, 0, 33, 9, 2};
   int plan_items [8] = '{40, 30, 40, 5, 25, 4, 50, 39};

   fir_filter_mac_top dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_command    (req_command),
      .req_coef_index (req_coef_index),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_filter_out (rsp_filter_out),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_tap_count  (csr_tap_count)
   );

   always #10 clock = ~clock;

   function automatic logic signed [fmac_pkg::OUT_W-1:0] predict_sample(
      input logic signed [fmac_pkg::VALUE_W-1:0] x
   );
      int     n;
      int     k;
      int     pos;
      longint acc;
      n = int'(taps_reg);
      if (n == 0) begin
         n = 1;
      end
      if (n > fmac_pkg::MAX_TAPS) begin
         n = fmac_pkg::MAX_TAPS;
      end
      pos = (newest_pos + 1) % fmac_pkg::MAX_TAPS;
      newest_pos = pos;
      hist_mem[pos] = x;
      acc = 0;
      for (k = 0; k < n; k++) begin
         acc += longint'(coef_mem[k]) * longint'(hist_mem[pos]);
         pos = (pos == 0) ? fmac_pkg::MAX_TAPS - 1 : pos - 1;
      end
      return acc[fmac_pkg::OUT_W-1:0];
   endfunction

   function automatic logic signed [fmac_pkg::VALUE_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'h0000;
         3: return 16'hffff;
         default: return fmac_pkg::VALUE_W'($urandom);
      endcase
   endfunction

   task automatic note_fail(input string msg);
      fail_count++;
      if (fail_count <= 10) begin
         $display("%s", msg);
      end
   endtask

   task automatic add_row(input row_kind_type k, input int idx, input int val,
                          input int taps, input bit typed, input longint known);
      stim_row_type r;
      r.kind      = k;
      r.idx       = fmac_pkg::INDEX_W'(idx);
      r.val       = fmac_pkg::VALUE_W'(val);
      r.taps      = fmac_pkg::CFG_W'(taps);
      r.typed     = typed;
      r.known_sum = fmac_pkg::OUT_W'(known);
      dir_rows.push_back(r);
   endtask

   // one req beat, with a random gap ahead of it
   task automatic send_beat(input logic cmd, input logic [fmac_pkg::INDEX_W-1:0] idx,
                            input logic signed [fmac_pkg::VALUE_W-1:0] val,
                            input bit typed,
                            input logic signed [fmac_pkg::OUT_W-1:0] known);
      logic signed [fmac_pkg::OUT_W-1:0] got;
      if ($urandom_range(0, 99) < send_idle) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < send_idle);
      end
      req_valid      <= 1'b1;
      req_command    <= cmd;
      req_coef_index <= idx;
      req_value      <= val;
      do @(posedge clock); while (!req_ready);
      if (cmd == fmac_pkg::CMD_LOAD) begin
         coef_mem[idx] = val;
      end else begin
         got = predict_sample(val);
         sum_queue.push_back(typed ? known : got);
      end
   endtask

   task automatic drain_filter();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sum_queue.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_taps(input logic [fmac_pkg::CFG_W-1:0] t);
      drain_filter();
      csr_valid     <= 1'b1;
      csr_tap_count <= t;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      taps_reg = t;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (sum_queue.size() == 0) begin
            note_fail($sformatf("unexpected rsp beat: filter_out %0d", rsp_filter_out));
         end else begin
            want_sum = sum_queue.pop_front();
            if (rsp_filter_out !== want_sum) begin
               note_fail($sformatf("filter_out mismatch: expected %0d, got %0d",
                                   want_sum, rsp_filter_out));
            end
         end
      end
      rsp_ready <= ($urandom_range(0, 99) >= recv_idle);
   end

   initial begin
      #20_000_000;
      $display("tb_fir_filter_mac_top: FAIL");
      $finish;
   end

   initial begin
      int                           i;
      int                           j;
      int                           p;
      logic [fmac_pkg::INDEX_W-1:0] idx;
      for (i = 0; i < fmac_pkg::MAX_TAPS; i++) begin
         hist_mem[i] = '0;
         coef_mem[i] = '0;
      end
      newest_pos = 0;
      taps_reg   = fmac_pkg::TAP_COUNT_RESET;
      send_idle  = 28;
      recv_idle  = 59;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // taps stay within the loaded coefficients for the whole run
      write_taps(fmac_pkg::CFG_W'(LOADED_TAPS));
      for (i = 0; i < LOADED_TAPS; i++) begin
         send_beat(fmac_pkg::CMD_LOAD, fmac_pkg::INDEX_W'(i),
                   fmac_pkg::VALUE_W'($urandom), 1'b0, '0);
      end

      // directed part
      add_row(ROW_LOAD, 0, -32768, 0, 0, 0);
      add_row(ROW_SAMPLE, 0, -32768, 0, 1, 64'd1073741824);
      add_row(ROW_LOAD, 0, 32767, 0, 0, 0);
      add_row(ROW_LOAD, 2047, 32767, 0, 0, 0);
      add_row(ROW_SAMPLE, 2047, 32767, 0, 0, 0);
      add_row(ROW_TAPS, 0, 0, 1, 0, 0);
      add_row(ROW_SAMPLE, 0, 0, 0, 1, 0);
      add_row(ROW_SAMPLE, 1365, -1, 0, 1, -32767);
      add_row(ROW_TAPS, 0, 0, 0, 0, 0);
      add_row(ROW_SAMPLE, 682, 32767, 0, 1, 64'd1073676289);
      add_row(ROW_TAPS, 0, 0, 4, 0, 0);
      add_row(ROW_LOAD, 0, -32768, 0, 0, 0);
      add_row(ROW_LOAD, 1, -32768, 0, 0, 0);
      add_row(ROW_LOAD, 2, -32768, 0, 0, 0);
      add_row(ROW_LOAD, 3, -32768, 0, 0, 0);
      add_row(ROW_SAMPLE, 0, -32768, 0, 0, 0);
      add_row(ROW_SAMPLE, 0, -32768, 0, 0, 0);
      add_row(ROW_SAMPLE, 0, -32768, 0, 0, 0);
      add_row(ROW_SAMPLE, 0, -32768, 0, 1, 64'd4294967296);
      add_row(ROW_TAPS, 0, 0, LOADED_TAPS, 0, 0);
      add_row(ROW_SAMPLE, 0, 12345, 0, 0, 0);
      for (i = 0; i < dir_rows.size(); i++) begin
         case (dir_rows[i].kind)
            ROW_TAPS: begin
               write_taps(dir_rows[i].taps);
            end
            ROW_LOAD: begin
               send_beat(fmac_pkg::CMD_LOAD, dir_rows[i].idx, dir_rows[i].val, 1'b0, '0);
            end
            default: begin
               send_beat(fmac_pkg::CMD_FILTER, dir_rows[i].idx, dir_rows[i].val,
                         dir_rows[i].typed, dir_rows[i].known_sum);
            end
         endcase
      end

      // random part, one tap count per stretch
      for (p = 0; p < 8; p++) begin
         if (p < 3) begin
            send_idle = 28;
            recv_idle = 59;
         end else if (p < 6) begin
            send_idle = 59;
            recv_idle = 28;
         end else begin
            send_idle = 0;
            recv_idle = 0;
         end
         write_taps(fmac_pkg::CFG_W'(plan_taps[p]));
         for (j = 0; j < plan_items[p]; j++) begin
            if ($urandom_range(0, 99) < 30) begin
               if ($urandom_range(0, 1) == 1) begin
                  idx = fmac_pkg::INDEX_W'($urandom_range(0, 15));
               end else begin
                  idx = fmac_pkg::INDEX_W'($urandom);
               end
               send_beat(fmac_pkg::CMD_LOAD, idx, pick_value(), 1'b0, '0);
            end else begin
               send_beat(fmac_pkg::CMD_FILTER, fmac_pkg::INDEX_W'($urandom),
                         pick_value(), 1'b0, '0);
            end
         end
      end

      req_valid <= 1'b0;
      while (sum_queue.size() != 0) @(posedge clock);
      repeat (64) @(posedge clock);
      if (fail_count == 0) begin
         $display("tb_fir_filter_mac_top: PASS");
      end else begin
         $display("tb_fir_filter_mac_top: FAIL");
      end
      $finish;
   end

endmodule

>>> filelist.f
hdl/fmac_pkg.sv
hdl/fmac_datapath.sv
hdl/fmac_controller.sv
hdl/fir_filter_mac_top.sv
hdl/fmac_checker.sv
sim/tb_fir_filter_mac_top.sv
